// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file sks_checker.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent true -> consequent true in the same cycle
`define SKS_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("assertion failed");

// antecedent true -> consequent true in the next cycle
`define SKS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/sks_pkg.sv =====
// ----------------------------------------------------------------------------
// sks_pkg
// Shared codes, widths and types of the sorted key set.
// ----------------------------------------------------------------------------
package sks_pkg;

	localparam int KEY_W = 32;
	localparam int OP_W  = 2;
	localparam int ST_W  = 2;
	localparam int POS_W = 6;

	localparam logic [OP_W-1:0] OP_TEST   = 2'd0;
	localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

	localparam logic [ST_W-1:0] STAT_OK      = 2'd0;
	localparam logic [ST_W-1:0] STAT_PRESENT = 2'd1;
	localparam logic [ST_W-1:0] STAT_ABSENT  = 2'd2;
	localparam logic [ST_W-1:0] STAT_FULL    = 2'd3;

	typedef struct packed {
		logic shift_up;
		logic shift_dn;
	} cell_ctl_t;

endpackage

// ===== rtl/sks_if.sv =====
// ----------------------------------------------------------------------------
// sks_req_if / sks_rsp_if
// Valid/ready channels for requests and their results.
// ----------------------------------------------------------------------------
interface sks_req_if;
	logic                                  valid;
	logic                                  ready;
	logic        [sks_pkg::OP_W-1:0]       operation;
	logic signed [sks_pkg::KEY_W-1:0]      key;

	modport source (output valid, operation, key, input ready);
	modport sink   (input valid, operation, key, output ready);
endinterface

interface sks_rsp_if;
	logic                           valid;
	logic                           ready;
	logic                           success;
	logic [sks_pkg::ST_W-1:0]       status;
	logic [sks_pkg::POS_W-1:0]      position;
	logic [sks_pkg::POS_W-1:0]      entries_held;

	modport source (output valid, success, status, position, entries_held, input ready);
	modport sink   (input valid, success, status, position, entries_held, output ready);
endinterface

// ===== rtl/sks_cell.sv =====
// ----------------------------------------------------------------------------
// sks_cell
// One slot of the sorted store: holds a key, compares it with the request
// key and takes its left neighbor's key or the request key on an insert, or its right neighbor's key on a delete.
// ----------------------------------------------------------------------------
module sks_cell #(
	parameter int INDEX = 0,
	parameter int CW    = 6
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [CW-1:0]                    count,
	input  logic signed [sks_pkg::KEY_W-1:0] key_in,
	input  sks_pkg::cell_ctl_t               ctl,
	input  logic signed [sks_pkg::KEY_W-1:0] left_key,
	input  logic signed [sks_pkg::KEY_W-1:0] right_key,
	input  logic                             left_lt,
	output logic signed [sks_pkg::KEY_W-1:0] key_out,
	output logic                             lt_s1,
	output logic                             eq_s1
);

	logic signed [sks_pkg::KEY_W-1:0] key_q;
	logic                             occupied;

	assign occupied = CW'(INDEX) < count;
	assign key_out  = key_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lt_s1 <= 1'b0;
			eq_s1 <= 1'b0;
		end else begin
			lt_s1 <= occupied && (key_q < key_in);
			eq_s1 <= occupied && (key_q == key_in);
		end
	end

	// slots below the lower bound keep their key
	always_ff @(posedge clk) begin
		if (ctl.shift_up && !lt_s1) begin
			key_q <= left_lt ? key_in : left_key;
		end else if (ctl.shift_dn && !lt_s1) begin
			key_q <= right_key;
		end
	end

endmodule

// ===== rtl/sorted_key_set_top.sv =====
// ----------------------------------------------------------------------------
// sorted_key_set_top
// Sorted set of unique signed 32-bit keys with test, add and remove.
// ----------------------------------------------------------------------------
// Keys sit in ascending order in a row of CAPACITY cells. A request passes
// through the states S_CMP and S_UPD: in S_CMP every cell compares its key
// with the request key, in S_UPD the lower bound is picked from the row of
// compare flags and, for a successful add or remove, every cell from that
// point on takes its neighbor's key, or the lower-bound cell the request key
// on an add, in one step. A new request is taken in the cycle the previous
// one finishes, not before; a waiting result holds S_UPD until it is taken.
// No clearing is needed after reset.
module sorted_key_set_top #(
	parameter int CAPACITY = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	sks_req_if.sink      req,
	sks_rsp_if.source    rsp
);

	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_CMP  = 3'b010,
		S_UPD  = 3'b100
	} state_t;

	state_t state_q, state_d;

	logic        [sks_pkg::OP_W-1:0]  op_q;
	logic signed [sks_pkg::KEY_W-1:0] key_q;
	logic        [CW-1:0]             count_q;

	logic signed [sks_pkg::KEY_W-1:0] cell_key [CAPACITY];
	logic signed [sks_pkg::KEY_W-1:0] left_key [CAPACITY];
	logic signed [sks_pkg::KEY_W-1:0] right_key [CAPACITY];
	logic [CAPACITY-1:0]              lt_vec, eq_vec, left_lt;

	sks_pkg::cell_ctl_t ctl;

	logic          out_free, fire, accept, found, add_ok, rem_ok;
	logic [CW-1:0] pos;
	logic [CW-1:0] count_d;

	logic                          rsp_valid_q;
	logic                          success_q;
	logic [sks_pkg::ST_W-1:0]      status_q;
	logic [sks_pkg::POS_W-1:0]     position_q, entries_q;
	logic [CW+sks_pkg::POS_W-1:0]  pos_ext, cnt_ext;

	assign out_free  = !rsp_valid_q || rsp.ready;
	assign fire      = (state_q == S_UPD) && out_free;
	assign req.ready = (state_q == S_IDLE) || fire;
	assign accept    = req.valid && req.ready;

	generate
		for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
			if (i == 0) begin : g_first
				assign left_key[i] = key_q;
				assign left_lt[i]  = 1'b1;
			end else begin : g_mid
				assign left_key[i] = cell_key[i-1];
				assign left_lt[i]  = lt_vec[i-1];
			end
			if (i == CAPACITY - 1) begin : g_last
				assign right_key[i] = cell_key[i];
			end else begin : g_inner
				assign right_key[i] = cell_key[i+1];
			end

			sks_cell #(
				.INDEX (i),
				.CW    (CW)
			) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.count     (count_q),
				.key_in    (key_q),
				.ctl       (ctl),
				.left_key  (left_key[i]),
				.right_key (right_key[i]),
				.left_lt   (left_lt[i]),
				.key_out   (cell_key[i]),
				.lt_s1     (lt_vec[i]),
				.eq_s1     (eq_vec[i])
			);
		end
	endgenerate

	// lower bound: the one cell where the less-than run ends, or CAPACITY if the run covers every cell
	always_comb begin
		pos = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (left_lt[i] && !lt_vec[i]) begin
				pos = pos | CW'(i);
			end
		end
		if (lt_vec[CAPACITY-1]) begin
			pos = pos | CW'(CAPACITY);
		end
	end

	assign found  = |eq_vec;
	assign add_ok = (op_q == sks_pkg::OP_ADD) && !found && (count_q < CW'(CAPACITY));
	assign rem_ok = (op_q == sks_pkg::OP_REMOVE) && found;

	assign ctl.shift_up = fire && add_ok;
	assign ctl.shift_dn = fire && rem_ok;

	always_comb begin
		priority if (add_ok) begin
			count_d = count_q + CW'(1);
		end else if (rem_ok) begin
			count_d = count_q - CW'(1);
		end else begin
			count_d = count_q;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (accept) state_d = S_CMP;
			S_CMP:  state_d = S_UPD;
			S_UPD: begin
				if (fire) state_d = accept ? S_CMP : S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fire) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= req.operation;
			key_q <= req.key;
		end
	end

	assign pos_ext = {{sks_pkg::POS_W{1'b0}}, pos};
	assign cnt_ext = {{sks_pkg::POS_W{1'b0}}, count_d};

	always_ff @(posedge clk) begin
		if (fire) begin
			position_q <= pos_ext[sks_pkg::POS_W-1:0];
			entries_q  <= cnt_ext[sks_pkg::POS_W-1:0];
			unique case (op_q)
				sks_pkg::OP_TEST: begin
					success_q <= found;
					status_q  <= found ? sks_pkg::STAT_OK : sks_pkg::STAT_ABSENT;
				end
				sks_pkg::OP_ADD: begin
					success_q <= add_ok;
					priority if (found) begin
						status_q <= sks_pkg::STAT_PRESENT;
					end else if (!add_ok) begin
						status_q <= sks_pkg::STAT_FULL;
					end else begin
						status_q <= sks_pkg::STAT_OK;
					end
				end
				sks_pkg::OP_REMOVE: begin
					success_q <= rem_ok;
					status_q  <= rem_ok ? sks_pkg::STAT_OK : sks_pkg::STAT_ABSENT;
				end
				default: begin
					success_q <= 1'b0;
					status_q  <= sks_pkg::STAT_OK;
				end
			endcase
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.success      = success_q;
	assign rsp.status       = status_q;
	assign rsp.position     = position_q;
	assign rsp.entries_held = entries_q;

endmodule

// ===== rtl/sks_checker.sv =====
// ----------------------------------------------------------------------------
// sks_checker
// Port-level checks of the sorted key set, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sks_checker #(
	parameter int CAPACITY = 32
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_ready,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic                         success,
	input logic [sks_pkg::ST_W-1:0]     status,
	input logic [sks_pkg::POS_W-1:0]    position,
	input logic [sks_pkg::POS_W-1:0]    entries_held
);

	localparam logic [31:0] CAP_W = CAPACITY;

	`SKS_ASSERT_NEXT(a_busy_after_req, clk, arst_n, req_valid && req_ready, !req_ready)

	`SKS_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready,
		rsp_valid && $stable(success) && $stable(status) && $stable(position) &&
		$stable(entries_held))

	`SKS_ASSERT_SAME(a_success_ok, clk, arst_n, rsp_valid && success,
		status == sks_pkg::STAT_OK)

	`SKS_ASSERT_SAME(a_full_count, clk, arst_n, rsp_valid && status == sks_pkg::STAT_FULL,
		entries_held == CAP_W[sks_pkg::POS_W-1:0])

endmodule

bind sorted_key_set_top sks_checker #(
	.CAPACITY (CAPACITY)
) u_sks_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.success      (rsp.success),
	.status       (rsp.status),
	.position     (rsp.position),
	.entries_held (rsp.entries_held)
);

// ===== test/sorted_key_set_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_set_top_tb
// Self-checking bench for the sorted key set. A driver feeds test, add,
// remove and unused-code requests from a queue; every accepted request
// updates a local sorted copy of the set that predicts the result, and a
// monitor compares each result field with the oldest prediction. Idle rates
// change per phase and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module sorted_key_set_top_tb;

	localparam int CAPACITY       = 32;
	localparam int RAND_PER_PHASE = 470;
	localparam int BURST_ITEMS    = 60;
	localparam int HOLD_CYCLES    = 400;
	localparam int DRAIN_CYCLES   = 20;
	localparam int CYCLE_LIMIT    = 200000;
	localparam int POOL_SIZE      = 40;
	localparam logic [sks_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [sks_pkg::OP_W-1:0]         operation;
		logic signed [sks_pkg::KEY_W-1:0] key;
	} set_req_t;

	typedef struct packed {
		logic                      success;
		logic [sks_pkg::ST_W-1:0]  status;
		logic [sks_pkg::POS_W-1:0] position;
		logic [sks_pkg::POS_W-1:0] entries_held;
	} set_rsp_t;

	logic clk;
	logic arst_n;

	sks_req_if req_ch ();
	sks_rsp_if rsp_ch ();

	sorted_key_set_top #(
		.CAPACITY(CAPACITY)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	set_req_t pending_reqs[$];
	set_rsp_t expected_rsps[$];
	int       stored_keys[$];
	int       key_pool[POOL_SIZE];
	int       send_idle_pct;
	int       recv_idle_pct;
	int       offered_cnt;
	int       accepted_cnt;
	int       hold_asks;
	int       error_cnt;
	int       cycle_cnt;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// lower bound search, then apply the request to the local copy
	function automatic set_rsp_t apply_set_request(set_req_t r);
		set_rsp_t res;
		int       k;
		int       lo;
		int       hi;
		int       mid;
		bit       found;
		k  = r.key;
		lo = 0;
		hi = stored_keys.size();
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			if (stored_keys[mid] < k)
				lo = mid + 1;
			else
				hi = mid;
		end
		found       = (lo < stored_keys.size()) && (stored_keys[lo] == k);
		res.success = 1'b0;
		res.status  = sks_pkg::STAT_OK;
		case (r.operation)
			sks_pkg::OP_TEST: begin
				res.success = found;
				res.status  = found ? sks_pkg::STAT_OK : sks_pkg::STAT_ABSENT;
			end
			sks_pkg::OP_ADD: begin
				if (found)
					res.status = sks_pkg::STAT_PRESENT;
				else if (stored_keys.size() >= CAPACITY)
					res.status = sks_pkg::STAT_FULL;
				else begin
					stored_keys.insert(lo, k);
					res.success = 1'b1;
				end
			end
			sks_pkg::OP_REMOVE: begin
				if (!found)
					res.status = sks_pkg::STAT_ABSENT;
				else begin
					stored_keys.delete(lo);
					res.success = 1'b1;
				end
			end
			default: ;
		endcase
		res.position     = lo[sks_pkg::POS_W-1:0];
		res.entries_held = sks_pkg::POS_W'(stored_keys.size());
		return res;
	endfunction

	function automatic set_req_t make_req(logic [sks_pkg::OP_W-1:0] op, int k);
		set_req_t r;
		r.operation = op;
		r.key       = k;
		return r;
	endfunction

	// grow mode favors adds, shrink mode favors removes
	function automatic set_req_t random_req(bit grow);
		int                        pick;
		int                        k;
		logic [sks_pkg::OP_W-1:0]  op;
		pick = $urandom_range(99);
		if (grow)
			op = (pick < 55) ? sks_pkg::OP_ADD : (pick < 75) ? sks_pkg::OP_REMOVE :
				(pick < 97) ? sks_pkg::OP_TEST : OP_UNUSED;
		else
			op = (pick < 20) ? sks_pkg::OP_ADD : (pick < 65) ? sks_pkg::OP_REMOVE :
				(pick < 97) ? sks_pkg::OP_TEST : OP_UNUSED;
		if ($urandom_range(9) == 0)
			k = $urandom;
		else
			k = key_pool[$urandom_range(POOL_SIZE - 1)];
		return make_req(op, k);
	endfunction

	task automatic report_field(string name, int exp_val, int act_val);
		if (exp_val != act_val) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d",
				$time, name, exp_val, act_val);
			error_cnt++;
		end
	endtask

	// request driver
	always @(negedge clk) begin
		if (!arst_n)
			req_ch.valid <= 1'b0;
		else if (req_ch.valid && offered_cnt != accepted_cnt)
			;
		else if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
			req_ch.valid     <= 1'b1;
			req_ch.operation <= pending_reqs[0].operation;
			req_ch.key       <= pending_reqs[0].key;
			offered_cnt++;
		end else
			req_ch.valid <= 1'b0;
	end

	// result ready, with a long hold-off on request
	int hold_served;
	int hold_left;
	always @(negedge clk) begin
		if (hold_asks != hold_served) begin
			hold_served = hold_asks;
			hold_left   = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ch.ready <= 1'b0;
		end else
			rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// monitor: check results, then record accepted requests
	always @(posedge clk) begin
		set_rsp_t exp_rsp;
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("%0t ns: timeout", $time);
			$display("end of test: mismatches");
			$finish;
		end
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_rsps.size() == 0) begin
				$display("%0t ns: unexpected result, expected none, actual %0d/%0d/%0d/%0d",
					$time, rsp_ch.success, rsp_ch.status, rsp_ch.position,
					rsp_ch.entries_held);
				error_cnt++;
			end else begin
				exp_rsp = expected_rsps.pop_front();
				report_field("success", exp_rsp.success, rsp_ch.success);
				report_field("status", exp_rsp.status, rsp_ch.status);
				report_field("position", exp_rsp.position, rsp_ch.position);
				report_field("entries_held", exp_rsp.entries_held, rsp_ch.entries_held);
			end
		end
		if (arst_n && req_ch.valid && req_ch.ready) begin
			expected_rsps.push_back(apply_set_request(pending_reqs.pop_front()));
			accepted_cnt++;
		end
	end

	initial begin
		int i;
		int phase;
		arst_n           = 1'b0;
		clk              = 1'b0;
		req_ch.valid     = 1'b0;
		req_ch.operation = sks_pkg::OP_TEST;
		req_ch.key       = '0;
		rsp_ch.ready     = 1'b0;
		send_idle_pct    = 27;
		recv_idle_pct    = 82;
		offered_cnt      = 0;
		accepted_cnt     = 0;
		hold_asks        = 0;
		hold_served      = 0;
		hold_left        = 0;
		error_cnt        = 0;
		cycle_cnt        = 0;

		key_pool[0] = 32'sh8000_0000;
		key_pool[1] = 32'sh7fff_ffff;
		key_pool[2] = 0;
		key_pool[3] = -1;
		key_pool[4] = 1;
		key_pool[5] = 32'sh8000_0001;
		key_pool[6] = 32'sh7fff_fffe;
		key_pool[7] = 2;
		for (i = 8; i < 24; i++)
			key_pool[i] = $urandom;
		for (i = 24; i < POOL_SIZE; i++)
			key_pool[i] = $urandom_range(40) - 20;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// directed: empty store, extremes, duplicates, absent keys, unused code
		pending_reqs.push_back(make_req(sks_pkg::OP_TEST, 0));
		pending_reqs.push_back(make_req(sks_pkg::OP_REMOVE, 5));
		pending_reqs.push_back(make_req(OP_UNUSED, 32'sh8000_0000));
		pending_reqs.push_back(make_req(sks_pkg::OP_ADD, 0));
		pending_reqs.push_back(make_req(sks_pkg::OP_ADD, 32'sh8000_0000));
		pending_reqs.push_back(make_req(sks_pkg::OP_ADD, 32'sh7fff_ffff));
		pending_reqs.push_back(make_req(sks_pkg::OP_ADD, -1));
		pending_reqs.push_back(make_req(sks_pkg::OP_ADD, 1));
		pending_reqs.push_back(make_req(sks_pkg::OP_ADD, 0));
		pending_reqs.push_back(make_req(sks_pkg::OP_TEST, 32'sh8000_0000));
		pending_reqs.push_back(make_req(sks_pkg::OP_TEST, 32'sh7fff_ffff));
		pending_reqs.push_back(make_req(sks_pkg::OP_TEST, 2));
		pending_reqs.push_back(make_req(sks_pkg::OP_TEST, -2));
		pending_reqs.push_back(make_req(sks_pkg::OP_TEST, 32'sh7fff_fffe));
		pending_reqs.push_back(make_req(sks_pkg::OP_REMOVE, -1));
		pending_reqs.push_back(make_req(sks_pkg::OP_REMOVE, -1));
		pending_reqs.push_back(make_req(OP_UNUSED, 1));
		pending_reqs.push_back(make_req(OP_UNUSED, 32'sh7fff_ffff));
		pending_reqs.push_back(make_req(sks_pkg::OP_REMOVE, 32'sh8000_0000));
		pending_reqs.push_back(make_req(sks_pkg::OP_REMOVE, 32'sh7fff_ffff));
		pending_reqs.push_back(make_req(sks_pkg::OP_ADD, 100));
		pending_reqs.push_back(make_req(sks_pkg::OP_TEST, 100));

		// sender pause until every queued request has been answered
		while (pending_reqs.size() != 0 || expected_rsps.size() != 0)
			@(posedge clk);

		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 27;
					recv_idle_pct = 82;
				end
				1: begin
					send_idle_pct = 82;
					recv_idle_pct = 27;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
					hold_asks++;
					for (i = 0; i < BURST_ITEMS; i++)
						pending_reqs.push_back(random_req(1'b1));
				end
			endcase
			for (i = 0; i < RAND_PER_PHASE; i++) begin
				while (pending_reqs.size() >= 8)
					@(posedge clk);
				pending_reqs.push_back(random_req(((i / 80) % 2) == 0));
			end
		end

		while (pending_reqs.size() != 0 || expected_rsps.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_cnt == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/sks_pkg.sv
rtl/sks_if.sv
rtl/sks_cell.sv
rtl/sorted_key_set_top.sv
rtl/sks_checker.sv
test/sorted_key_set_top_tb.sv
